[rtl/ctw_pkg.sv]
// Shared types, codes and constants of the capacitive touch wheel decoder.
package ctw_pkg;

	localparam int CNT_W = 12;
	localparam int IDX_W = 4;
	localparam int ACT_W = 3;
	localparam int DUTY_W = 20;
	localparam int POS_W = 14;
	localparam int TOT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] sensor_t;

	// Result action codes.
	localparam logic [ACT_W-1:0] ACT_NOTHING = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET_DUTY = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_TIMEOUT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_OVERRUN = 3'd5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEB_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEB_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LED_GAIN = 2'd3;

	// Output of the shared subtract and compare unit.
	typedef struct packed {
		count_t diff;
		logic   lt;
	} alu_res_t;

	// Control of the winner ring.
	typedef struct packed {
		logic    release_all;
		logic    wr;
		sensor_t wdata;
	} ring_ctrl_t;

endpackage

[rtl/ctw_alu.sv]
// Shared subtract and compare unit of the touch wheel decoder.
module ctw_alu (
	input  ctw_pkg::count_t   a,
	input  ctw_pkg::count_t   b,
	output ctw_pkg::alu_res_t res
);
	import ctw_pkg::*;

	logic [CNT_W:0] full;

	// The borrow out of a - b tells a < b; the low bits are the difference.
	assign full = {1'b0, a} - {1'b0, b};
	assign res.diff = full[CNT_W-1:0];
	assign res.lt = full[CNT_W];

endmodule

[rtl/ctw_ring.sv]
// Ring of recent winning sensors with its write pointer and agreement flag.
module ctw_ring #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctw_pkg::ring_ctrl_t ctrl,
	output logic                agree
);
	import ctw_pkg::*;

	localparam int PW = $clog2(DEPTH);

	sensor_t       ring_q [DEPTH];
	logic [PW-1:0] ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			ptr_q <= '0;
		end else if (ctrl.release_all) begin
			// A release fills the ring with distinct values so it cannot agree.
			for (int i = 0; i < DEPTH; i++) begin
				ring_q[i] <= IDX_W'(i);
			end
		end else if (ctrl.wr) begin
			ring_q[ptr_q] <= ctrl.wdata;
			if (ptr_q == PW'(DEPTH - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_comb begin
		agree = 1'b1;
		for (int i = 0; i + 1 < DEPTH; i++) begin
			if (ring_q[i] != ring_q[i+1]) begin
				agree = 1'b0;
			end
		end
	end

endmodule

[rtl/cap_touch_wheel_decoder.sv]
// Top level of the capacitive touch wheel decoder: sequencer, sensor stores and result register.
// A timeout, overrun or flagless item goes from idle to the output state, a debounce-held
// touch via decode; a decoded touch then via max scan, ring, check, neighbors, difference and
// multiply (output after check if the ring disagrees); no-touch adds the false-release scan.
// The one shared subtract and compare unit walks the sensors one per cycle in each scan.
// No new item is taken until the last result is loaded; in_ready is high only in the idle state.
// Reset clears stores, counters and the ring and resets all registers but the result payload.
module cap_touch_wheel_decoder #(
	parameter int N_SENSORS = 6,
	parameter int CHAIN_DEPTH = 4,
	parameter int SLICE_SPAN = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write port.
	input  logic                                  cfg_we,
	input  logic [ctw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ctw_pkg::CFG_DATA_W-1:0]        cfg_data,
	// Event channel.
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  yes_touch,
	input  logic                                  no_touch,
	input  logic                                  timed_out,
	input  logic                                  overran,
	input  ctw_pkg::sensor_t                      sensor_index,
	input  ctw_pkg::count_t                       sensor_count,
	// Result channel.
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ctw_pkg::ACT_W-1:0]             action,
	output ctw_pkg::sensor_t                      winner_index,
	output logic [ctw_pkg::DUTY_W-1:0]            duty_value,
	output logic signed [ctw_pkg::POS_W-1:0]      wheel_position,
	output logic [ctw_pkg::TOT_W-1:0]             timeout_total,
	output logic [ctw_pkg::TOT_W-1:0]             overrun_total
);
	import ctw_pkg::*;

	localparam int SIW = $clog2(N_SENSORS);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FR   = 4'd1;
	localparam logic [3:0] S_DEC  = 4'd2;
	localparam logic [3:0] S_MAX  = 4'd3;
	localparam logic [3:0] S_RING = 4'd4;
	localparam logic [3:0] S_CHK  = 4'd5;
	localparam logic [3:0] S_NBL  = 4'd6;
	localparam logic [3:0] S_NBR  = 4'd7;
	localparam logic [3:0] S_DIFF = 4'd8;
	localparam logic [3:0] S_MUL  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	// Configuration registers.
	count_t     thr_q;
	logic [7:0] deb_len_q;
	logic       deb_en_q;
	logic [7:0] gain_q;

	// Sensor stores and decoder state.
	count_t          raw_q   [N_SENSORS];
	count_t          touch_q [N_SENSORS];
	logic [SIW-1:0]  cur_q;
	logic [7:0]      deb_cnt_q;
	logic            deb_done_q;
	logic [TOT_W-1:0] tmo_cnt_q;
	logic [TOT_W-1:0] ovr_cnt_q;

	// Working registers of the item in flight.
	logic [3:0]      st_q;
	logic            yes_q;
	logic            fr_q;
	count_t          cnt_q;
	logic [SIW-1:0]  n_q;
	logic [SIW-1:0]  w_q;
	count_t          best_q;
	count_t          nl_q;
	count_t          nsel_q;
	logic            left_q;
	count_t          diff_q;
	logic [ACT_W-1:0] act_q;
	logic [DUTY_W-1:0] duty_q;
	logic [POS_W-1:0] pos_q;

	// Result register.
	logic              out_valid_q;
	logic [ACT_W-1:0]  out_act_q;
	sensor_t           out_win_q;
	logic [DUTY_W-1:0] out_duty_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [TOT_W-1:0]  out_tmo_q;
	logic [TOT_W-1:0]  out_ovr_q;

	logic           in_xfer;
	logic           out_load;
	logic           idx_ok;
	logic           last_n;
	logic [SIW-1:0] left_idx;
	logic [SIW-1:0] right_idx;
	logic [SIW-1:0] tc_addr;
	count_t         tc_rd;
	count_t         alu_a;
	count_t         alu_b;
	alu_res_t       alu_res;
	ring_ctrl_t     ring_ctrl;
	logic           agree;
	logic [8:0]     deb_next;
	logic [POS_W-1:0] span_lo;
	logic [POS_W-1:0] span_hi;

	assign in_ready = (st_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign idx_ok = ({1'b0, sensor_index} < (IDX_W + 1)'(N_SENSORS));
	assign last_n = (n_q == SIW'(N_SENSORS - 1));

	// The result register takes a new result when it is empty or being emptied.
	assign out_load = (st_q == S_OUT) && (!out_valid_q || out_ready);

	// Neighbors of the winner on the closed wheel.
	assign left_idx = (w_q == '0) ? SIW'(N_SENSORS - 1) : w_q - 1'b1;
	assign right_idx = (w_q == SIW'(N_SENSORS - 1)) ? '0 : w_q + 1'b1;

	// The touch store has one read port; the sequencer picks its address.
	always_comb begin
		case (st_q)
			S_NBL:   tc_addr = left_idx;
			S_NBR:   tc_addr = right_idx;
			default: tc_addr = n_q;
		endcase
	end
	assign tc_rd = touch_q[tc_addr];

	// Operand selection for the shared unit.
	always_comb begin
		case (st_q)
			S_FR: begin
				alu_a = raw_q[n_q];
				alu_b = thr_q;
			end
			S_MAX: begin
				alu_a = best_q;
				alu_b = tc_rd;
			end
			S_NBR: begin
				alu_a = nl_q;
				alu_b = tc_rd;
			end
			default: begin
				alu_a = best_q;
				alu_b = nsel_q;
			end
		endcase
	end

	ctw_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign deb_next = {1'b0, deb_cnt_q} + 9'd1;

	// Ring control: written once per decoded touch, refilled on a real release.
	always_comb begin
		ring_ctrl.wr = (st_q == S_RING);
		ring_ctrl.wdata = IDX_W'(w_q);
		ring_ctrl.release_all = (st_q == S_DEC) && !(yes_q || fr_q);
	end

	ctw_ring #(
		.DEPTH (CHAIN_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.agree  (agree)
	);

	// Slice boundaries around the winner.
	assign span_lo = POS_W'(w_q) * POS_W'(SLICE_SPAN);
	assign span_hi = span_lo + POS_W'(SLICE_SPAN);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			deb_len_q <= 8'd4;
			deb_en_q <= 1'b1;
			gain_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:  thr_q <= cfg_data[CNT_W-1:0];
				REG_DEB_LENGTH: deb_len_q <= cfg_data[7:0];
				REG_DEB_ENABLE: deb_en_q <= cfg_data[0];
				REG_LED_GAIN:   gain_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Sequencer and decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int i = 0; i < N_SENSORS; i++) begin
				raw_q[i] <= '0;
				touch_q[i] <= '0;
			end
			cur_q <= '0;
			deb_cnt_q <= '0;
			deb_done_q <= 1'b0;
			tmo_cnt_q <= '0;
			ovr_cnt_q <= '0;
			yes_q <= 1'b0;
			fr_q <= 1'b0;
			cnt_q <= '0;
			n_q <= '0;
			w_q <= '0;
			best_q <= '0;
			nl_q <= '0;
			nsel_q <= '0;
			left_q <= 1'b0;
			diff_q <= '0;
			act_q <= ACT_NOTHING;
			duty_q <= '0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_xfer) begin
						yes_q <= yes_touch;
						cnt_q <= sensor_count;
						fr_q <= 1'b0;
						n_q <= '0;
						act_q <= ACT_NOTHING;
						w_q <= '0;
						duty_q <= '0;
						pos_q <= '0;
						if (idx_ok) begin
							cur_q <= sensor_index[SIW-1:0];
							raw_q[sensor_index[SIW-1:0]] <= sensor_count;
						end
						// Touch and no-touch win over timeout, timeout over overrun.
						if (yes_touch) begin
							st_q <= S_DEC;
						end else if (no_touch) begin
							st_q <= S_FR;
						end else if (timed_out) begin
							tmo_cnt_q <= tmo_cnt_q + 1'b1;
							act_q <= ACT_TIMEOUT;
							st_q <= S_OUT;
						end else if (overran) begin
							ovr_cnt_q <= ovr_cnt_q + 1'b1;
							act_q <= ACT_OVERRUN;
							st_q <= S_OUT;
						end else begin
							st_q <= S_OUT;
						end
					end
				end
				S_FR: begin
					// A no-touch while any sensor still reads below threshold is a false release.
					if (alu_res.lt) begin
						fr_q <= 1'b1;
					end
					n_q <= n_q + 1'b1;
					if (last_n) begin
						st_q <= S_DEC;
					end
				end
				S_DEC: begin
					n_q <= '0;
					if (yes_q || fr_q) begin
						if (deb_en_q && !deb_done_q && (deb_next < {1'b0, deb_len_q})) begin
							deb_cnt_q <= deb_next[7:0];
							st_q <= S_OUT;
						end else begin
							if (deb_en_q && !deb_done_q) begin
								deb_cnt_q <= '0;
								deb_done_q <= 1'b1;
							end
							touch_q[cur_q] <= cnt_q;
							st_q <= S_MAX;
						end
					end else begin
						deb_cnt_q <= '0;
						deb_done_q <= 1'b0;
						act_q <= ACT_RELEASE;
						st_q <= S_OUT;
					end
				end
				S_MAX: begin
					// Strictly larger replaces the winner, so ties keep the lower index.
					if (n_q == '0 || alu_res.lt) begin
						w_q <= n_q;
						best_q <= tc_rd;
					end
					n_q <= n_q + 1'b1;
					if (last_n) begin
						st_q <= S_RING;
					end
				end
				S_RING: begin
					st_q <= S_CHK;
				end
				S_CHK: begin
					if (agree) begin
						st_q <= S_NBL;
					end else begin
						act_q <= ACT_CLEAR;
						w_q <= '0;
						st_q <= S_OUT;
					end
				end
				S_NBL: begin
					nl_q <= tc_rd;
					st_q <= S_NBR;
				end
				S_NBR: begin
					left_q <= !alu_res.lt;
					nsel_q <= alu_res.lt ? tc_rd : nl_q;
					st_q <= S_DIFF;
				end
				S_DIFF: begin
					diff_q <= alu_res.diff;
					st_q <= S_MUL;
				end
				S_MUL: begin
					duty_q <= DUTY_W'(gain_q) * DUTY_W'(diff_q);
					if (left_q) begin
						pos_q <= POS_W'(diff_q) + span_lo;
					end else begin
						pos_q <= span_hi - POS_W'(diff_q);
					end
					act_q <= ACT_SET_DUTY;
					st_q <= S_OUT;
				end
				S_OUT: begin
					// Hand the result over once the result register is free.
					if (out_load) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload; loaded together with out_valid_q.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_act_q <= act_q;
			out_win_q <= IDX_W'(w_q);
			out_duty_q <= duty_q;
			out_pos_q <= pos_q;
			out_tmo_q <= tmo_cnt_q;
			out_ovr_q <= ovr_cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign action = out_act_q;
	assign winner_index = out_win_q;
	assign duty_value = out_duty_q;
	assign wheel_position = signed'(out_pos_q);
	assign timeout_total = out_tmo_q;
	assign overrun_total = out_ovr_q;

	// An accepted event always keeps the sequencer busy for the next cycle.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("event channel ready right after a transfer");

	// Only a set-duty result carries a winner, a duty and a position.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action != ACT_SET_DUTY) |->
			(duty_value == '0 && wheel_position == '0 && winner_index == '0))
		else $error("non-zero decode fields on a result other than set duty");

	// The timeout counter moves only on the transfer of an event.
	a_tmo_on_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(tmo_cnt_q != $past(tmo_cnt_q)) |-> $past(in_xfer && timed_out))
		else $error("timeout counter changed without a timeout event");

	// The sensor scan never runs past the last sensor.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_MAX || st_q == S_FR) |->
			({1'b0, n_q} < (SIW + 1)'(N_SENSORS)))
		else $error("sensor scan index out of range");

endmodule

[sim/wheel_tb_pkg.sv]
// Event and result types plus the result tracker used by the wheel decoder testbench.
package wheel_tb_pkg;

	import ctw_pkg::*;

	localparam int WHEEL_SENSORS = 6;
	localparam int RING_DEPTH = 4;
	localparam int SLICE_UNITS = 30;

	typedef struct packed {
		logic    touched;
		logic    untouched;
		logic    tmo;
		logic    ovr;
		sensor_t idx;
		count_t  cnt;
	} touch_event_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		sensor_t           winner;
		logic [DUTY_W-1:0] duty;
		logic [POS_W-1:0]  pos;
		logic [TOT_W-1:0]  tmo_total;
		logic [TOT_W-1:0]  ovr_total;
	} wheel_outcome_t;

	class wheel_tracker;
		logic [CNT_W-1:0] threshold;
		logic [7:0]       deb_len;
		logic             deb_on;
		logic [7:0]       gain;
		count_t           raw_cnt[WHEEL_SENSORS];
		count_t           tch_cnt[WHEEL_SENSORS];
		sensor_t          ring[RING_DEPTH];
		int               ring_ptr;
		sensor_t          cur;
		int               deb_cnt;
		bit               deb_done;
		logic [TOT_W-1:0] tmo_total;
		logic [TOT_W-1:0] ovr_total;
		wheel_outcome_t   awaited[$];
		int               faults;

		function new();
			threshold = '0;
			deb_len = 8'd4;
			deb_on = 1'b1;
			gain = 8'd1;
			foreach (raw_cnt[n]) begin
				raw_cnt[n] = '0;
				tch_cnt[n] = '0;
			end
			foreach (ring[n])
				ring[n] = '0;
			ring_ptr = 0;
			cur = '0;
			deb_cnt = 0;
			deb_done = 0;
			tmo_total = '0;
			ovr_total = '0;
			faults = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_THRESHOLD: threshold = data;
				REG_DEB_LENGTH: deb_len = data[7:0];
				REG_DEB_ENABLE: deb_on = data[0];
				REG_LED_GAIN: gain = data[7:0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted event and queues it.
		function void note_event(touch_event_t ev);
			wheel_outcome_t o;
			bit false_rel, held, agree;
			int w, lft, rgt, c, posn, diff;
			o = '0;
			if (ev.idx < WHEEL_SENSORS) begin
				cur = ev.idx;
				raw_cnt[ev.idx] = ev.cnt;
			end
			if (ev.touched || ev.untouched) begin
				false_rel = 0;
				if (ev.untouched)
					foreach (raw_cnt[n])
						if (raw_cnt[n] < threshold)
							false_rel = 1;
				if (ev.touched || false_rel) begin
					held = 0;
					if (deb_on && !deb_done) begin
						c = deb_cnt + 1;
						if (c < deb_len) begin
							deb_cnt = c;
							held = 1;
						end else begin
							deb_cnt = 0;
							deb_done = 1;
						end
					end
					if (!held) begin
						tch_cnt[cur] = ev.cnt;
						w = 0;
						for (int n = 1; n < WHEEL_SENSORS; n++)
							if (tch_cnt[n] > tch_cnt[w])
								w = n;
						ring[ring_ptr] = sensor_t'(w);
						ring_ptr = (ring_ptr + 1) % RING_DEPTH;
						agree = 1;
						for (int n = 0; n + 1 < RING_DEPTH; n++)
							if (ring[n] != ring[n + 1])
								agree = 0;
						if (agree) begin
							lft = (w + WHEEL_SENSORS - 1) % WHEEL_SENSORS;
							rgt = (w + 1) % WHEEL_SENSORS;
							if (tch_cnt[lft] >= tch_cnt[rgt]) begin
								diff = int'(tch_cnt[w]) - int'(tch_cnt[lft]);
								posn = diff + w * SLICE_UNITS;
							end else begin
								diff = int'(tch_cnt[w]) - int'(tch_cnt[rgt]);
								posn = (w + 1) * SLICE_UNITS - diff;
							end
							o.duty = DUTY_W'(int'(gain) * diff);
							o.winner = sensor_t'(w);
							o.pos = posn[POS_W-1:0];
							o.action = ACT_SET_DUTY;
						end else begin
							o.action = ACT_CLEAR;
						end
					end
				end else begin
					// A real release re-arms the debounce and breaks the ring.
					deb_done = 0;
					deb_cnt = 0;
					foreach (ring[n])
						ring[n] = sensor_t'(n);
					o.action = ACT_RELEASE;
				end
			end else if (ev.tmo) begin
				tmo_total = tmo_total + 1;
				o.action = ACT_TIMEOUT;
			end else if (ev.ovr) begin
				ovr_total = ovr_total + 1;
				o.action = ACT_OVERRUN;
			end
			o.tmo_total = tmo_total;
			o.ovr_total = ovr_total;
			awaited.push_back(o);
		endfunction

		function void check_outcome(wheel_outcome_t got);
			wheel_outcome_t want;
			if (awaited.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: action %0d winner %0d duty %0d pos %0d",
						got.action, got.winner, got.duty, $signed(got.pos));
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				faults++;
				if (faults <= 10) begin
					$display("mismatch: action %0d/%0d winner %0d/%0d duty %0d/%0d",
						want.action, got.action, want.winner, got.winner,
						want.duty, got.duty);
					$display("  pos %0d/%0d timeouts %0d/%0d overruns %0d/%0d",
						$signed(want.pos), $signed(got.pos), want.tmo_total,
						got.tmo_total, want.ovr_total, got.ovr_total);
				end
			end
		endfunction
	endclass

endpackage

[sim/tb_cap_touch_wheel_decoder.sv]
// Testbench top level for the capacitive touch wheel decoder.
module tb_cap_touch_wheel_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import ctw_pkg::*;
	import wheel_tb_pkg::*;

	// Even with long idle and stall stretches a full run stays far below this bound.
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_EVENTS = 172;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  yes_touch;
	logic                  no_touch;
	logic                  timed_out;
	logic                  overran;
	sensor_t               sensor_index;
	count_t                sensor_count;
	logic                  out_valid;
	logic                  out_ready;
	logic [ACT_W-1:0]      action;
	sensor_t               winner_index;
	logic [DUTY_W-1:0]     duty_value;
	logic signed [POS_W-1:0] wheel_position;
	logic [TOT_W-1:0]      timeout_total;
	logic [TOT_W-1:0]      overrun_total;

	wheel_tracker tracker;
	int send_idle_pct;
	int recv_stall_pct;
	int events_sent;
	int cycles;

	cap_touch_wheel_decoder #(
		.N_SENSORS(WHEEL_SENSORS),
		.CHAIN_DEPTH(RING_DEPTH),
		.SLICE_SPAN(SLICE_UNITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.yes_touch(yes_touch),
		.no_touch(no_touch),
		.timed_out(timed_out),
		.overran(overran),
		.sensor_index(sensor_index),
		.sensor_count(sensor_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.action(action),
		.winner_index(winner_index),
		.duty_value(duty_value),
		.wheel_position(wheel_position),
		.timeout_total(timeout_total),
		.overrun_total(overrun_total)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The result side drops ready at random, decided at each falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			tracker.check_outcome({action, winner_index, duty_value, wheel_position,
				timeout_total, overrun_total});

	// Writes one register while the block is idle and mirrors it in the tracker.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(idx, data);
	endtask

	// Offers one event and holds it until the transfer. The sender may idle first;
	// valid stays high after a transfer until the next falling edge decides again.
	task automatic send_event(input logic y, input logic nt, input logic tm, input logic ov,
		input sensor_t idx, input count_t cnt);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		yes_touch <= y;
		no_touch <= nt;
		timed_out <= tm;
		overran <= ov;
		sensor_index <= idx;
		sensor_count <= cnt;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_event({y, nt, tm, ov, idx, cnt});
		events_sent++;
	endtask

	// Lowers valid and waits until every expected result has come back, then lets
	// the block settle for more than its longest latency.
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// One finger on the wheel: a stable count profile with a clear peak, scanned in
	// random sensor order so that the winner ring fills and agrees, usually followed
	// by a lift-off. A few taps carry extra flags to mix in the flag priority.
	task automatic run_gesture();
		count_t profile[WHEEL_SENSORS];
		int peak, pk, taps;
		sensor_t s;
		peak = $urandom_range(64, 4095);
		pk = $urandom_range(0, WHEEL_SENSORS - 1);
		foreach (profile[k])
			profile[k] = count_t'($urandom_range(0, peak / 2));
		profile[pk] = count_t'(peak);
		profile[(pk + 1) % WHEEL_SENSORS] = count_t'($urandom_range(0, peak));
		profile[(pk + WHEEL_SENSORS - 1) % WHEEL_SENSORS] = count_t'($urandom_range(0, peak));
		taps = $urandom_range(4, 14);
		repeat (taps) begin
			s = sensor_t'($urandom_range(0, WHEEL_SENSORS - 1));
			send_event(1'b1, $urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0,
				$urandom_range(0, 19) == 0, s, profile[s]);
		end
		if ($urandom_range(0, 9) < 7)
			send_event(1'b0, 1'b1, $urandom_range(0, 7) == 0, 1'b0,
				sensor_t'($urandom_range(0, WHEEL_SENSORS - 1)),
				count_t'($urandom_range(0, 4095)));
	endtask

	// One setting of the registers and of the idling, then mostly gestures with
	// bursts of fully random events in between.
	task automatic run_phase(input int thr, input int len, input int en, input int gain,
		input int idle_pct, input int stall_pct);
		int start;
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_DEB_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_DEB_ENABLE, CFG_DATA_W'(en));
		write_reg(REG_LED_GAIN, CFG_DATA_W'(gain));
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = events_sent;
		while (events_sent - start < PHASE_EVENTS) begin
			if ($urandom_range(0, 99) < 80)
				run_gesture();
			else
				repeat ($urandom_range(1, 4))
					send_event($urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 1),
						sensor_t'($urandom), count_t'($urandom));
		end
		wait_quiet();
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		yes_touch = 1'b0;
		no_touch = 1'b0;
		timed_out = 1'b0;
		overran = 1'b0;
		sensor_index = '0;
		sensor_count = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		events_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings, with no idling on either side.
		// An event with no flag only stores the raw count.
		send_event(1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 12'hFFF);
		send_event(1'b0, 1'b0, 1'b1, 1'b0, 4'd3, 12'h000);
		send_event(1'b0, 1'b0, 1'b0, 1'b1, 4'd4, 12'h555);
		// Timeout wins over overrun, and touch wins over both.
		send_event(1'b0, 1'b0, 1'b1, 1'b1, 4'd15, 12'hAAA);
		send_event(1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 12'h000);
		// The next taps are held by the debounce until it completes.
		send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd2, 12'd100);
		send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd3, 12'd50);
		// Full-scale count on sensor 5: the debounce completes and the ring fills.
		repeat (4) send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd5, 12'hFFF);
		// An index past the last sensor keeps sensor 5 as the current one, and the ring agrees.
		send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd9, 12'hFFF);
		// A tie at full scale goes to the lowest index.
		send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 12'hFFF);
		// A real release, then a right neighbor larger than the left one, which
		// drives the wheel position far negative.
		send_event(1'b0, 1'b1, 1'b0, 1'b0, 4'd1, 12'h800);
		repeat (4) send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd5, 12'h000);
		repeat (3) send_event(1'b1, 1'b0, 1'b0, 1'b0, 4'd1, 12'h001);
		wait_quiet();

		// With the threshold at its top a no-touch event is a false release, and the
		// largest gain pushes the duty toward its full range.
		write_reg(REG_THRESHOLD, 12'hFFF);
		write_reg(REG_LED_GAIN, 12'd255);
		repeat (2) send_event(1'b0, 1'b1, 1'b0, 1'b0, 4'd2, 12'h123);
		send_event(1'b0, 1'b1, 1'b0, 1'b0, 4'd0, 12'hFFF);
		wait_quiet();

		// Random part: threshold, debounce length and gain go through their
		// extremes, the debounce is also switched off, and a zero length is tried.
		run_phase(0, 1, 1, 255, 0, 0);
		run_phase(4095, 255, 1, 0, 56, 0);
		run_phase($urandom_range(0, 4095), 0, 1, $urandom_range(0, 255), 0, 56);
		run_phase($urandom_range(0, 800), 2, 1, 1, 16, 16);
		run_phase(0, 4, 0, 200, 56, 0);
		run_phase($urandom_range(0, 4095), $urandom_range(1, 8), 1,
			$urandom_range(0, 255), 0, 56);
		run_phase(1, 3, 1, 255, 16, 16);
		run_phase($urandom_range(0, 4095), $urandom_range(0, 6), $urandom_range(0, 1),
			$urandom_range(0, 255), 0, 0);

		if (tracker.faults == 0 && tracker.awaited.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/ctw_pkg.sv
rtl/ctw_alu.sv
rtl/ctw_ring.sv
rtl/cap_touch_wheel_decoder.sv
sim/wheel_tb_pkg.sv
sim/tb_cap_touch_wheel_decoder.sv
